FILE: rtl/efss_pkg.sv
// ----------------------------------------------------------------------------
// efss_pkg
// Shared types and action codes for the event FIFO with spill slot.
// ----------------------------------------------------------------------------
package efss_pkg;

    localparam int ACTION_W   = 2;
    localparam int KIND_W     = 2;
    localparam int REASON_W   = 8;
    localparam int SEQ_W      = 32;
    localparam int OVR_W      = 32;
    localparam int FILL_W     = 6;

    localparam logic [ACTION_W-1:0] ACT_PUSH     = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP      = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ_CLR = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [REASON_W-1:0] reason;
        logic [SEQ_W-1:0]    seq;
    } entry_t;

endpackage

FILE: rtl/efss_ram.sv
// ----------------------------------------------------------------------------
// efss_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module efss_ram #(
    parameter int WIDTH = 42,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/event_fifo_with_spill_slot_top.sv
// ----------------------------------------------------------------------------
// event_fifo_with_spill_slot_top
// Event queue: ring FIFO in RAM plus a single latest-entry spill slot.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one action per transfer:
//   push an event, pop an event, or read-and-clear the overrun count.
//   Every action yields exactly one result on the output channel
//   (out_valid / out_stall), held in an output register.
//   Push, read and unused actions: result appears the cycle after the
//   transfer, one action per cycle while out_stall is low. A pop that hits
//   the ring reads the RAM (registered read port) in ST_POP before the output
//   register is loaded; a pop from the spill slot or an empty queue does not.
//   The input is stalled while a ring read is in flight and while a result
//   sits in the output register with out_stall high; the next action is
//   taken in the same cycle the pending result is transferred out.
//   Reset clears pointers, counters, spill state and the output register;
//   the ring RAM itself is not cleared (entries are read only once written).
//   Pushes are stamped with a wrapping sequence number starting at 1.
// ----------------------------------------------------------------------------
module event_fifo_with_spill_slot_top #(
    parameter int RING_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [1:0]  event_kind,
    input  logic [7:0]  event_reason,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        have_item,
    output logic [1:0]  item_kind,
    output logic [7:0]  item_reason,
    output logic [31:0] item_sequence,
    output logic [31:0] overrun_total,
    output logic        spill_mode,
    output logic [5:0]  fill_level
);

    import efss_pkg::*;

    localparam int ADDR_W = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam logic [ADDR_W:0]   DEPTH_EXT = (ADDR_W + 1)'(RING_DEPTH);
    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(RING_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(RING_DEPTH - 1);

    typedef enum logic {
        ST_IDLE,
        ST_POP
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   rp_reg, rp_next;
    logic [CNT_W-1:0]    held_reg, held_next;
    logic [SEQ_W-1:0]    seq_reg, seq_next;
    logic [OVR_W-1:0]    ovr_reg, ovr_next;
    logic                spill_act_reg, spill_act_next;
    logic                spill_vld_reg, spill_vld_next;
    entry_t              spill_ent_reg, spill_ent_next;

    logic                out_valid_reg, out_valid_next;
    logic                have_item_reg, have_item_next;
    logic [KIND_W-1:0]   item_kind_reg, item_kind_next;
    logic [REASON_W-1:0] item_reason_reg, item_reason_next;
    logic [SEQ_W-1:0]    item_sequence_reg, item_sequence_next;
    logic [OVR_W-1:0]    overrun_total_reg, overrun_total_next;
    logic                spill_mode_reg, spill_mode_next;
    logic [FILL_W-1:0]   fill_level_reg, fill_level_next;

    logic                out_free;
    logic                in_xfer;
    logic                load_out;
    logic                ram_we;
    logic [ADDR_W:0]     tail_sum;
    logic [ADDR_W-1:0]   tail_addr;
    logic [ADDR_W-1:0]   rp_inc;
    entry_t              new_entry;
    entry_t              rd_entry;
    logic [CNT_W+FILL_W-1:0] fill_ext;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != ST_IDLE) || !out_free;
    assign in_xfer  = in_valid && !in_stall;

    // Tail = (rp + held) mod depth; only used when held < depth.
    assign tail_sum  = (ADDR_W + 1)'(rp_reg) + (ADDR_W + 1)'(held_reg[ADDR_W-1:0]);
    assign tail_addr = (tail_sum >= DEPTH_EXT) ? ADDR_W'(tail_sum - DEPTH_EXT)
                                               : tail_sum[ADDR_W-1:0];
    assign rp_inc    = (rp_reg == LAST_ADDR) ? '0 : rp_reg + 1'b1;

    assign new_entry.kind   = event_kind;
    assign new_entry.reason = event_reason;
    assign new_entry.seq    = seq_reg + 1'b1;

    efss_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (tail_addr),
        .wr_data (new_entry),
        .rd_addr (rp_reg),
        .rd_data (rd_entry)
    );

    always_comb
    begin
        state_next         = state_reg;
        rp_next            = rp_reg;
        held_next          = held_reg;
        seq_next           = seq_reg;
        ovr_next           = ovr_reg;
        spill_act_next     = spill_act_reg;
        spill_vld_next     = spill_vld_reg;
        spill_ent_next     = spill_ent_reg;
        out_valid_next     = out_valid_reg && out_stall;
        have_item_next     = have_item_reg;
        item_kind_next     = item_kind_reg;
        item_reason_next   = item_reason_reg;
        item_sequence_next = item_sequence_reg;
        overrun_total_next = overrun_total_reg;
        load_out           = 1'b0;
        ram_we             = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    have_item_next     = 1'b0;
                    item_kind_next     = '0;
                    item_reason_next   = '0;
                    item_sequence_next = '0;
                    overrun_total_next = '0;
                    out_valid_next     = 1'b1;
                    load_out           = 1'b1;
                    unique case (action)
                        ACT_PUSH:
                        begin
                            seq_next           = new_entry.seq;
                            item_sequence_next = new_entry.seq;
                            if (!spill_act_reg && held_reg != DEPTH_CNT)
                            begin
                                ram_we    = 1'b1;
                                held_next = held_reg + 1'b1;
                            end
                            else
                            begin
                                spill_act_next = 1'b1;
                                ovr_next       = ovr_reg + 1'b1;
                                spill_ent_next = new_entry;
                                spill_vld_next = 1'b1;
                            end
                        end
                        ACT_POP:
                        begin
                            if (held_reg != '0)
                            begin
                                // Ring hit: result comes from the RAM next cycle
                                rp_next        = rp_inc;
                                held_next      = held_reg - 1'b1;
                                out_valid_next = 1'b0;
                                state_next     = ST_POP;
                                if (held_next == '0 && !spill_vld_reg)
                                begin
                                    spill_act_next = 1'b0;
                                end
                            end
                            else
                            begin
                                spill_act_next = 1'b0;
                                if (spill_vld_reg)
                                begin
                                    spill_vld_next     = 1'b0;
                                    have_item_next     = 1'b1;
                                    item_kind_next     = spill_ent_reg.kind;
                                    item_reason_next   = spill_ent_reg.reason;
                                    item_sequence_next = spill_ent_reg.seq;
                                end
                            end
                        end
                        ACT_READ_CLR:
                        begin
                            overrun_total_next = ovr_reg;
                            ovr_next           = '0;
                        end
                        default:
                        begin
                            // unused code: status only
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    load_out           = 1'b1;
                    have_item_next     = 1'b1;
                    item_kind_next     = rd_entry.kind;
                    item_reason_next   = rd_entry.reason;
                    item_sequence_next = rd_entry.seq;
                    overrun_total_next = '0;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // fill_level is reported modulo 64
    assign fill_ext        = {{FILL_W{1'b0}}, held_next};
    assign fill_level_next = load_out ? fill_ext[FILL_W-1:0] : fill_level_reg;
    assign spill_mode_next = load_out ? spill_act_next : spill_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            rp_reg            <= '0;
            held_reg          <= '0;
            seq_reg           <= '0;
            ovr_reg           <= '0;
            spill_act_reg     <= 1'b0;
            spill_vld_reg     <= 1'b0;
            spill_ent_reg     <= '0;
            out_valid_reg     <= 1'b0;
            have_item_reg     <= 1'b0;
            item_kind_reg     <= '0;
            item_reason_reg   <= '0;
            item_sequence_reg <= '0;
            overrun_total_reg <= '0;
            spill_mode_reg    <= 1'b0;
            fill_level_reg    <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            rp_reg            <= rp_next;
            held_reg          <= held_next;
            seq_reg           <= seq_next;
            ovr_reg           <= ovr_next;
            spill_act_reg     <= spill_act_next;
            spill_vld_reg     <= spill_vld_next;
            spill_ent_reg     <= spill_ent_next;
            out_valid_reg     <= out_valid_next;
            have_item_reg     <= have_item_next;
            item_kind_reg     <= item_kind_next;
            item_reason_reg   <= item_reason_next;
            item_sequence_reg <= item_sequence_next;
            overrun_total_reg <= overrun_total_next;
            spill_mode_reg    <= spill_mode_next;
            fill_level_reg    <= fill_level_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign have_item     = have_item_reg;
    assign item_kind     = item_kind_reg;
    assign item_reason   = item_reason_reg;
    assign item_sequence = item_sequence_reg;
    assign overrun_total = overrun_total_reg;
    assign spill_mode    = spill_mode_reg;
    assign fill_level    = fill_level_reg;

endmodule

FILE: rtl/efss_checker.sv
// ----------------------------------------------------------------------------
// efss_checker
// Port-level assertions for the event FIFO with spill slot.
// ----------------------------------------------------------------------------
module efss_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [1:0]  action,
    input logic        out_valid,
    input logic        out_stall,
    input logic        have_item,
    input logic [1:0]  item_kind,
    input logic [7:0]  item_reason,
    input logic [31:0] item_sequence,
    input logic [31:0] overrun_total
);

    import efss_pkg::*;

    logic in_xfer;
    assign in_xfer = in_valid && !in_stall;

    // push result shows up next cycle, with no item and no overrun total
    a_push_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && action == ACT_PUSH |=> out_valid && !have_item && overrun_total == '0)
        else $error("push transfer did not produce a push result");

    // read-and-clear result shows up next cycle, with no item fields
    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && action == ACT_READ_CLR |=> out_valid && !have_item && item_sequence == '0)
        else $error("read transfer did not produce a read result");

    // item fields stay zero unless a pop returned an entry
    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !have_item |-> item_kind == '0 && item_reason == '0)
        else $error("item fields set without an item");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(item_sequence))
        else $error("stalled result changed");

endmodule

bind event_fifo_with_spill_slot_top efss_checker u_efss_checker (.*);

FILE: dv/event_queue_checker.sv
// ----------------------------------------------------------------------------
// event_queue_checker
// Watches both channels of the event FIFO, predicts the result of every
// accepted action from its own copy of the ring, spill slot and counters,
// and compares each delivered result against the oldest pending prediction.
// ----------------------------------------------------------------------------
module event_queue_checker #(
    parameter int RING_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  action,
    input  logic [1:0]  event_kind,
    input  logic [7:0]  event_reason,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        have_item,
    input  logic [1:0]  item_kind,
    input  logic [7:0]  item_reason,
    input  logic [31:0] item_sequence,
    input  logic [31:0] overrun_total,
    input  logic        spill_mode,
    input  logic [5:0]  fill_level,
    output int          pending_count,
    output int          fail_count
);

    import efss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               have;
        logic [KIND_W-1:0]  kind;
        logic [REASON_W-1:0] reason;
        logic [SEQ_W-1:0]   seq;
        logic [OVR_W-1:0]   total;
        logic               spill;
        logic [FILL_W-1:0]  fill;
    } queue_result_t;

    // shadow of the queue state
    entry_t          ring_shadow [RING_DEPTH];
    int unsigned     head_idx;
    int unsigned     held;
    logic [SEQ_W-1:0] seq_stamp;
    logic [OVR_W-1:0] overrun_cnt;
    logic            spill_on;
    logic            spill_full;
    entry_t          spill_shadow;

    queue_result_t   pending_results [$];
    int              mismatches;

    assign fail_count = mismatches;

    function automatic queue_result_t apply_queue_action(input logic [1:0] act,
                                                         input logic [1:0] kind,
                                                         input logic [7:0] reason);
        queue_result_t r;
        entry_t        e;
        r = '0;
        if (act == ACT_PUSH)
        begin
            seq_stamp = seq_stamp + 1'b1;
            e.kind    = kind;
            e.reason  = reason;
            e.seq     = seq_stamp;
            if (!spill_on && held < RING_DEPTH)
            begin
                ring_shadow[(head_idx + held) % RING_DEPTH] = e;
                held++;
            end
            else
            begin
                spill_on     = 1'b1;
                overrun_cnt  = overrun_cnt + 1'b1;
                spill_shadow = e;
                spill_full   = 1'b1;
            end
            r.seq = e.seq;
        end
        else if (act == ACT_POP)
        begin
            if (held > 0)
            begin
                e        = ring_shadow[head_idx];
                head_idx = (head_idx + 1) % RING_DEPTH;
                held--;
                r.have   = 1'b1;
                r.kind   = e.kind;
                r.reason = e.reason;
                r.seq    = e.seq;
            end
            else if (spill_full)
            begin
                spill_full = 1'b0;
                r.have     = 1'b1;
                r.kind     = spill_shadow.kind;
                r.reason   = spill_shadow.reason;
                r.seq      = spill_shadow.seq;
            end
            if (held == 0 && !spill_full)
                spill_on = 1'b0;
        end
        else if (act == ACT_READ_CLR)
        begin
            r.total     = overrun_cnt;
            overrun_cnt = '0;
        end
        r.spill = spill_on;
        r.fill  = held[FILL_W-1:0];
        return r;
    endfunction

    task automatic flag_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t mismatch on %s: expected 0x%0h, got 0x%0h",
                     $realtime, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        queue_result_t want;
        if (!rst_n)
        begin
            head_idx     = 0;
            held         = 0;
            seq_stamp    = '0;
            overrun_cnt  = '0;
            spill_on     = 1'b0;
            spill_full   = 1'b0;
            spill_shadow = '0;
            mismatches   = 0;
            pending_results.delete();
            pending_count <= 0;
        end
        else
        begin
            // the result leaving now always belongs to an earlier action
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t result transfer with nothing expected", $realtime);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (have_item !== want.have)
                        flag_field("have_item", want.have, have_item);
                    if (item_kind !== want.kind)
                        flag_field("item_kind", want.kind, item_kind);
                    if (item_reason !== want.reason)
                        flag_field("item_reason", want.reason, item_reason);
                    if (item_sequence !== want.seq)
                        flag_field("item_sequence", want.seq, item_sequence);
                    if (overrun_total !== want.total)
                        flag_field("overrun_total", want.total, overrun_total);
                    if (spill_mode !== want.spill)
                        flag_field("spill_mode", want.spill, spill_mode);
                    if (fill_level !== want.fill)
                        flag_field("fill_level", want.fill, fill_level);
                end
            end
            if (in_valid && !in_stall)
                pending_results.push_back(apply_queue_action(action, event_kind,
                                                             event_reason));
            pending_count <= pending_results.size();
        end
    end

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives push, pop, read-and-clear and unused actions into the event FIFO
// with random idle gaps and output back-pressure, including a long receiver
// hold-off and a full drain pause; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

    import efss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH   = 32;
    localparam int RANDOM_ITEMS = 1700;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_SLACK  = 20;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam logic [KIND_W-1:0] KIND_STA_START    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DISCONNECTED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GOT_ADDR     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BAD          = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [1:0]  event_kind;
    logic [7:0]  event_reason;
    logic        out_valid;
    logic        out_stall;
    logic        have_item;
    logic [1:0]  item_kind;
    logic [7:0]  item_reason;
    logic [31:0] item_sequence;
    logic [31:0] overrun_total;
    logic        spill_mode;
    logic [5:0]  fill_level;
    int          pending_count;
    int          fail_count;

    logic        hold_req;
    int unsigned cycles;

    event_fifo_with_spill_slot_top #(
        .RING_DEPTH(RING_DEPTH)
    ) u_top (
        .*
    );

    event_queue_checker #(
        .RING_DEPTH(RING_DEPTH)
    ) u_checker (
        .*
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // mostly short idles, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_action(input logic [1:0] act, input logic [1:0] kind,
                               input logic [7:0] reason, input int unsigned gap);
        in_valid     <= 1'b1;
        action       <= act;
        event_kind   <= kind;
        event_reason <= reason;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // receiver back-pressure, with one long hold-off on request
    initial
    begin
        int unsigned n;
        int unsigned calm_left;
        bit          hold_taken;
        out_stall  = 1'b0;
        calm_left  = 0;
        hold_taken = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (calm_left > 0)
            begin
                calm_left--;
            end
            else
            begin
                n = idle_len();
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
                calm_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
                                                        : $urandom_range(0, 8);
            end
        end
    end

    initial
    begin
        int unsigned sent;
        int unsigned seg_len;
        int unsigned mode;
        int unsigned pace;
        int unsigned roll;
        int unsigned push_pct;
        int unsigned pop_pct;
        int unsigned gap;
        logic [1:0]  act;
        cycles       = 0;
        hold_req     = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = ACT_PUSH;
        event_kind   = KIND_STA_START;
        event_reason = 8'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty queue, every action, field extremes
        send_action(ACT_POP, KIND_STA_START, 8'd0, 0);
        send_action(ACT_READ_CLR, KIND_STA_START, 8'd0, 0);
        send_action(ACT_UNUSED, KIND_BAD, 8'hFF, 1);
        send_action(ACT_PUSH, KIND_STA_START, 8'h00, 0);
        send_action(ACT_PUSH, KIND_DISCONNECTED, 8'hFF, 0);
        send_action(ACT_PUSH, KIND_GOT_ADDR, 8'hAA, 0);
        send_action(ACT_PUSH, KIND_BAD, 8'h55, 2);
        send_action(ACT_UNUSED, KIND_STA_START, 8'h00, 0);
        repeat (4) send_action(ACT_POP, KIND_STA_START, 8'h00, 0);
        send_action(ACT_POP, KIND_GOT_ADDR, 8'h81, 0);
        send_action(ACT_PUSH, KIND_GOT_ADDR, 8'h7E, 0);
        send_action(ACT_POP, KIND_STA_START, 8'h00, 0);
        send_action(ACT_READ_CLR, KIND_STA_START, 8'h00, 3);

        // random: segments biased toward filling, draining or mixing
        sent = 0;
        mode = 0;
        while (sent < RANDOM_ITEMS)
        begin
            seg_len = $urandom_range(20, 60);
            pace    = $urandom_range(0, 3);
            case (mode)
                0:       begin push_pct = 85; pop_pct = 8;  end
                1:       begin push_pct = 12; pop_pct = 78; end
                default: begin push_pct = 45; pop_pct = 45; end
            endcase
            repeat (seg_len)
            begin
                roll = $urandom_range(0, 99);
                if (roll < push_pct)
                    act = ACT_PUSH;
                else if (roll < push_pct + pop_pct)
                    act = ACT_POP;
                else if (roll < 97)
                    act = ACT_READ_CLR;
                else
                    act = ACT_UNUSED;
                gap = (pace != 0 && $urandom_range(0, 3) < pace) ? idle_len() : 0;
                if (sent == 500)
                    hold_req <= 1'b1;
                if (sent == 1100)
                begin
                    // let everything drain before offering more
                    in_valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (pending_count != 0);
                end
                send_action(act, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                            gap);
                sent++;
            end
            mode = $urandom_range(0, 2);
        end
        in_valid <= 1'b0;

        do
            @(posedge clk);
        while (pending_count != 0);
        repeat (DRAIN_SLACK) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: event_fifo_with_spill_slot_top.f
rtl/efss_pkg.sv
rtl/efss_ram.sv
rtl/event_fifo_with_spill_slot_top.sv
rtl/efss_checker.sv
dv/event_queue_checker.sv
dv/testbench.sv
